>>> rtl/quaternion_rotate_vector_top_macros.svh
// assertion macros for the quaternion rotation block
`ifndef QUATERNION_ROTATE_VECTOR_TOP_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_TOP_MACROS_SVH

// checked only while out of reset
`define QRV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define QRV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/qrv_pkg.sv
// shared constants and types for the quaternion rotation block
package qrv_pkg;

  localparam int QUAT_WIDTH         = 16;
  localparam int VEC_WIDTH          = 32;
  localparam int DIV_BITS_PER_STAGE = 4;

  typedef struct packed {
    logic valid;
    logic zero_quat;
  } qrv_ctl_t;

endpackage

>>> rtl/qrv_quad.sv
// product pipeline: forms the rotation numerators and the squared norm
module qrv_quad #(
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH,
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [QUAT_WIDTH-1:0]             q_i [4],
  input  logic signed [VEC_WIDTH-1:0]              v_i [3],
  output qrv_pkg::qrv_ctl_t                        ctl_o,
  input  logic                                     ready_i,
  output logic signed [2*QUAT_WIDTH+VEC_WIDTH+2:0] num_o [3],
  output logic [2*QUAT_WIDTH:0]                    n_o
);

  localparam int PQ   = 2*QUAT_WIDTH;
  localparam int PV   = QUAT_WIDTH + VEC_WIDTH;
  localparam int NW   = 2*QUAT_WIDTH + 1;
  localparam int SW   = 2*QUAT_WIDTH + 1;
  localparam int CW   = PV + 1;
  localparam int NUMW = 2*QUAT_WIDTH + VEC_WIDTH + 3;

  logic [3:0] vld_q;
  logic [3:0] en;
  logic [3:0] ld;

  // stage 1: squares and all component products
  logic signed [PQ-1:0]         sq_q [4];
  logic signed [PV-1:0]         pv_q [3][3];
  logic signed [QUAT_WIDTH-1:0] q1_q [4];
  logic signed [VEC_WIDTH-1:0]  v1_q [3];
  // stage 2: norm, dot, cross
  logic [NW-1:0]                n_d;
  logic [NW-1:0]                n2_q;
  logic                         zero2_q;
  logic signed [SW-1:0]         s2_q;
  logic signed [CW-1:0]         d2_q;
  logic signed [CW-1:0]         c2_q [3];
  logic signed [QUAT_WIDTH-1:0] q2_q [4];
  logic signed [VEC_WIDTH-1:0]  v2_q [3];
  // stage 3: second products
  logic [NW-1:0]                n3_q;
  logic                         zero3_q;
  logic signed [SW+VEC_WIDTH-1:0] ts_q [3];
  logic signed [CW+QUAT_WIDTH-1:0] td_q [3];
  logic signed [CW+QUAT_WIDTH-1:0] tc_q [3];
  // stage 4: numerators
  logic [NW-1:0]                n4_q;
  logic                         zero4_q;
  logic signed [NUMW-1:0]       num_q [3];

  always_comb begin
    en[3] = ~vld_q[3] | ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    ld[0] = en[0] & in_valid_i;
    for (int k = 1; k < 4; k++) begin
      ld[k] = en[k] & vld_q[k-1];
    end
  end

  assign n_d = NW'($unsigned(sq_q[0])) + NW'($unsigned(sq_q[1]))
             + NW'($unsigned(sq_q[2])) + NW'($unsigned(sq_q[3]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 4; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= q_i[i] * q_i[i];
        q1_q[i] <= q_i[i];
      end
      for (int i = 0; i < 3; i++) begin
        v1_q[i] <= v_i[i];
        for (int j = 0; j < 3; j++) begin
          pv_q[i][j] <= q_i[i+1] * v_i[j];
        end
      end
    end
    if (ld[1]) begin
      n2_q    <= n_d;
      zero2_q <= (n_d == '0);
      s2_q    <= SW'(sq_q[0]) - SW'(sq_q[1]) - SW'(sq_q[2]) - SW'(sq_q[3]);
      d2_q    <= CW'(pv_q[0][0]) + CW'(pv_q[1][1]) + CW'(pv_q[2][2]);
      c2_q[0] <= CW'(pv_q[1][2]) - CW'(pv_q[2][1]);
      c2_q[1] <= CW'(pv_q[2][0]) - CW'(pv_q[0][2]);
      c2_q[2] <= CW'(pv_q[0][1]) - CW'(pv_q[1][0]);
      q2_q    <= q1_q;
      v2_q    <= v1_q;
    end
    if (ld[2]) begin
      n3_q    <= n2_q;
      zero3_q <= zero2_q;
      for (int j = 0; j < 3; j++) begin
        ts_q[j] <= s2_q * v2_q[j];
        td_q[j] <= d2_q * q2_q[j+1];
        tc_q[j] <= q2_q[0] * c2_q[j];
      end
    end
    if (ld[3]) begin
      n4_q    <= n3_q;
      zero4_q <= zero3_q;
      // (w^2 - u.u) v + 2 (u.v) u + 2 w (u x v)
      for (int j = 0; j < 3; j++) begin
        num_q[j] <= NUMW'(ts_q[j]) + (NUMW'(td_q[j]) <<< 1) + (NUMW'(tc_q[j]) <<< 1);
      end
    end
  end

  assign in_ready_o      = en[0];
  assign ctl_o.valid     = vld_q[3];
  assign ctl_o.zero_quat = zero4_q;
  assign num_o           = num_q;
  assign n_o             = n4_q;

endmodule

>>> rtl/qrv_divider.sv
// pipelined rounding divider with saturation, three lanes sharing one divisor
module qrv_divider #(
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH,
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  qrv_pkg::qrv_ctl_t                        ctl_i,
  output logic                                     ready_o,
  input  logic signed [2*QUAT_WIDTH+VEC_WIDTH+2:0] num_i [3],
  input  logic [2*QUAT_WIDTH:0]                    n_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [VEC_WIDTH-1:0]              r_o [3],
  output logic                                     err_o,
  output logic                                     sat_o
);

  localparam int NUMW = 2*QUAT_WIDTH + VEC_WIDTH + 3;
  localparam int NW   = 2*QUAT_WIDTH + 1;
  localparam int DW   = NW + 1;
  localparam int XW   = NUMW + 1;
  localparam int BPS  = qrv_pkg::DIV_BITS_PER_STAGE;
  localparam int NST  = (VEC_WIDTH + BPS - 1) / BPS;
  localparam int LAST = NST + 1;
  localparam logic [VEC_WIDTH-1:0] MAG_POS = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] MAG_NEG = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic [LAST:0] vld_q;
  logic [LAST:0] en;
  logic [LAST:0] ld;

  logic [DW-1:0]        dvs_q  [NST+1];
  logic [2:0]           neg_q  [NST+1];
  logic [NST:0]         zero_q;
  logic [DW-1:0]        rem_q  [NST+1][3];
  logic [VEC_WIDTH-1:0] low_q  [NST+1][3];
  logic [DW-1:0]        rem_nx [NST+1][3];
  logic [VEC_WIDTH-1:0] low_nx [NST+1][3];
  logic [2:0]           neg_d;

  logic [VEC_WIDTH-1:0] res_d  [3];
  logic [2:0]           clip;
  logic [VEC_WIDTH-1:0] r_q    [3];
  logic                 err_q;
  logic                 sat_q;

  always_comb begin
    en[LAST] = ~vld_q[LAST] | out_ready_i;
    for (int k = LAST-1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    ld[0] = en[0] & ctl_i.valid;
    for (int k = 1; k <= LAST; k++) begin
      ld[k] = en[k] & vld_q[k-1];
    end
  end

  // dividend 2|num| + n over divisor 2n rounds half away from zero;
  // the quotient stays below 2^VEC_WIDTH, so the top bits start the remainder
  always_comb begin
    logic [NUMW-1:0] mag;
    logic [XW-1:0]   dvd;
    for (int j = 0; j < 3; j++) begin
      neg_d[j]     = num_i[j][NUMW-1];
      mag          = neg_d[j] ? (~num_i[j] + 1'b1) : num_i[j];
      dvd          = {mag, 1'b0} + XW'(n_i);
      rem_nx[0][j] = DW'(dvd[XW-1:VEC_WIDTH]);
      low_nx[0][j] = dvd[VEC_WIDTH-1:0];
    end
  end

  for (genvar k = 1; k <= NST; k++) begin : g_div
    localparam int DONE  = (k-1)*BPS;
    localparam int NSTEP = (VEC_WIDTH - DONE > BPS) ? BPS : (VEC_WIDTH - DONE);

    // quotient bits shift into the low word as dividend bits leave it
    always_comb begin
      logic [DW:0]          trial;
      logic [DW-1:0]        rem;
      logic [VEC_WIDTH-1:0] low;
      logic                 qb;
      for (int j = 0; j < 3; j++) begin
        rem = rem_q[k-1][j];
        low = low_q[k-1][j];
        for (int s = 0; s < NSTEP; s++) begin
          trial = {rem, low[VEC_WIDTH-1]};
          qb    = (trial >= {1'b0, dvs_q[k-1]});
          if (qb) begin
            trial = trial - {1'b0, dvs_q[k-1]};
          end
          rem = trial[DW-1:0];
          low = {low[VEC_WIDTH-2:0], qb};
        end
        rem_nx[k][j] = rem;
        low_nx[k][j] = low;
      end
    end
  end

  always_comb begin
    logic [VEC_WIDTH-1:0] lim;
    logic [VEC_WIDTH-1:0] m;
    for (int j = 0; j < 3; j++) begin
      lim      = neg_q[NST][j] ? MAG_NEG : MAG_POS;
      clip[j]  = (low_q[NST][j] > lim);
      m        = clip[j] ? lim : low_q[NST][j];
      res_d[j] = neg_q[NST][j] ? (~m + 1'b1) : m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= ctl_i.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      dvs_q[0]  <= {n_i, 1'b0};
      neg_q[0]  <= neg_d;
      zero_q[0] <= ctl_i.zero_quat;
    end
    for (int k = 1; k <= NST; k++) begin
      if (ld[k]) begin
        dvs_q[k]  <= dvs_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
    for (int k = 0; k <= NST; k++) begin
      if (ld[k]) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[k][j] <= rem_nx[k][j];
          low_q[k][j] <= low_nx[k][j];
        end
      end
    end
    if (ld[LAST]) begin
      for (int j = 0; j < 3; j++) begin
        r_q[j] <= zero_q[NST] ? '0 : res_d[j];
      end
      err_q <= zero_q[NST];
      sat_q <= ~zero_q[NST] & (|clip);
    end
  end

  assign ready_o     = en[0];
  assign out_valid_o = vld_q[LAST];
  assign err_o       = err_q;
  assign sat_o       = sat_q;
  for (genvar j = 0; j < 3; j++) begin : g_out
    assign r_o[j] = r_q[j];
  end

endmodule

>>> rtl/quaternion_rotate_vector_top.sv
// Rotates a vector (signed Q16.16) by a quaternion (signed Q2.14) of any
// nonzero length, normalizing by its squared norm, with round-to-nearest and
// saturation of each component; an all-zero quaternion gives a zero vector and
// sets zero_quat_error_o. One word can enter every cycle while the output is
// not stalled. The product pipeline forms the products and sums, then a divider
// pipeline resolves four quotient bits per stage, framed by a sign/rounding
// stage and the saturating output register.
// Each stage holds its word only while the next one is full, so a stall at the
// output fills bubbles before input back-pressure appears.
`include "quaternion_rotate_vector_top_macros.svh"

module quaternion_rotate_vector_top #(
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH,
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [QUAT_WIDTH-1:0] q_w_i,
  input  logic signed [QUAT_WIDTH-1:0] q_x_i,
  input  logic signed [QUAT_WIDTH-1:0] q_y_i,
  input  logic signed [QUAT_WIDTH-1:0] q_z_i,
  input  logic signed [VEC_WIDTH-1:0]  v_x_i,
  input  logic signed [VEC_WIDTH-1:0]  v_y_i,
  input  logic signed [VEC_WIDTH-1:0]  v_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [VEC_WIDTH-1:0]  r_x_o,
  output logic signed [VEC_WIDTH-1:0]  r_y_o,
  output logic signed [VEC_WIDTH-1:0]  r_z_o,
  output logic                         zero_quat_error_o,
  output logic                         saturated_o
);

  localparam int NUMW = 2*QUAT_WIDTH + VEC_WIDTH + 3;
  localparam logic [VEC_WIDTH-1:0] R_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] R_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic signed [QUAT_WIDTH-1:0] q_in [4];
  logic signed [VEC_WIDTH-1:0]  v_in [3];
  logic signed [NUMW-1:0]       num  [3];
  logic [2*QUAT_WIDTH:0]        n;
  qrv_pkg::qrv_ctl_t            ctl;
  logic                         div_ready;
  logic signed [VEC_WIDTH-1:0]  r    [3];

  assign q_in[0] = q_w_i;
  assign q_in[1] = q_x_i;
  assign q_in[2] = q_y_i;
  assign q_in[3] = q_z_i;
  assign v_in[0] = v_x_i;
  assign v_in[1] = v_y_i;
  assign v_in[2] = v_z_i;

  qrv_quad #(
    .QUAT_WIDTH(QUAT_WIDTH),
    .VEC_WIDTH (VEC_WIDTH)
  ) u_quad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .q_i       (q_in),
    .v_i       (v_in),
    .ctl_o     (ctl),
    .ready_i   (div_ready),
    .num_o     (num),
    .n_o       (n)
  );

  qrv_divider #(
    .QUAT_WIDTH(QUAT_WIDTH),
    .VEC_WIDTH (VEC_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .ready_o    (div_ready),
    .num_i      (num),
    .n_i        (n),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .r_o        (r),
    .err_o      (zero_quat_error_o),
    .sat_o      (saturated_o)
  );

  assign r_x_o = r[0];
  assign r_y_o = r[1];
  assign r_z_o = r[2];

  // zero quaternion word must come out all zero and unclipped
  `QRV_ASSERT(a_zero_quat_clear, (out_valid_o && zero_quat_error_o) |-> (r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && !saturated_o), "zero quaternion word not cleared")
  // a clipped word has some component at a range limit
  `QRV_ASSERT(a_sat_at_limit, (out_valid_o && saturated_o) |-> (r_x_o == R_MAX || r_x_o == R_MIN || r_y_o == R_MAX || r_y_o == R_MIN || r_z_o == R_MAX || r_z_o == R_MIN), "saturated flag without a clipped component")
  // an open output never back-pressures the input
  `QRV_ASSERT(a_no_false_stall, (!out_valid_o || out_ready_i) |-> in_ready_o, "input stalled while output drains")
  `QRV_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

>>> sim/tb_top.sv
// testbench for the quaternion vector rotation block
module tb_top;

  localparam int QW = qrv_pkg::QUAT_WIDTH;
  localparam int VW = qrv_pkg::VEC_WIDTH;

  typedef struct {
    logic signed [VW-1:0] rx, ry, rz;
    logic                 zerr, sat;
  } rot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [QW-1:0] q_w_i = '0, q_x_i = '0, q_y_i = '0, q_z_i = '0;
  logic signed [VW-1:0] v_x_i = '0, v_y_i = '0, v_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [VW-1:0] r_x_o, r_y_o, r_z_o;
  logic zero_quat_error_o, saturated_o;

  rot_t rot_q[$];
  int   errors = 0;
  bit   hold_off = 0;
  bit   rx_busy = 0;

  quaternion_rotate_vector_top u_dut (.*);

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // rounded, saturated num / n
  function automatic logic signed [VW-1:0] div_round(logic signed [127:0] num,
                                                     logic signed [127:0] n,
                                                     ref logic sat);
    logic        neg;
    logic [127:0] mag, q, lim;
    neg = num[127];
    mag = neg ? -num : num;
    q = (2 * mag + n) / (2 * n);
    lim = neg ? (128'd1 << (VW - 1)) : ((128'd1 << (VW - 1)) - 1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[VW-1:0] : q[VW-1:0];
  endfunction

  function automatic rot_t rotate(logic signed [QW-1:0] w, x, y, z,
                                  logic signed [VW-1:0] vx, vy, vz);
    logic signed [127:0] sw, sx, sy, sz, ax, ay, az, n, s, d, nx, ny, nz;
    rot_t r;
    logic sat;
    sw = w; sx = x; sy = y; sz = z; ax = vx; ay = vy; az = vz;
    n = sw * sw + sx * sx + sy * sy + sz * sz;
    r = '{default: '0};
    if (n == 0) begin
      r.zerr = 1'b1;
      return r;
    end
    sat = 1'b0;
    s = sw * sw - (sx * sx + sy * sy + sz * sz);
    d = 2 * (sx * ax + sy * ay + sz * az);
    nx = s * ax + d * sx + 2 * sw * (sy * az - sz * ay);
    ny = s * ay + d * sy + 2 * sw * (sz * ax - sx * az);
    nz = s * az + d * sz + 2 * sw * (sx * ay - sy * ax);
    r.rx = div_round(nx, n, sat);
    r.ry = div_round(ny, n, sat);
    r.rz = div_round(nz, n, sat);
    r.sat = sat;
    return r;
  endfunction

  int gap_left = 0;
  int burst_left = 0;

  // offer one word, holding it until accepted; a new burst may start after an idle gap
  task automatic send_rot(logic signed [QW-1:0] w, x, y, z,
                          logic signed [VW-1:0] vx, vy, vz);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    q_w_i <= w; q_x_i <= x; q_y_i <= y; q_z_i <= z;
    v_x_i <= vx; v_y_i <= vy; v_z_i <= vz;
    do @(posedge clk_i); while (!in_ready_o);
    rot_q.push_back(rotate(w, x, y, z, vx, vy, vz));
  endtask

  // receiver stall pattern plus the long hold-off
  initial begin
    int mode;
    forever begin
      @(posedge clk_i);
      mode = $urandom_range(0, 99);
      if (hold_off) out_ready_i <= 1'b0;
      else if (!rx_busy) out_ready_i <= 1'b1;
      else out_ready_i <= (mode < 65);
    end
  end

  always @(posedge clk_i) begin
    rot_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rot_q.size() == 0) begin
        $display("%0t: unexpected word r=%h %h %h", $time, r_x_o, r_y_o, r_z_o);
        errors++;
      end else begin
        e = rot_q.pop_front();
        if (r_x_o !== e.rx) begin
          $display("%0t: r_x exp %h got %h", $time, e.rx, r_x_o); errors++;
        end
        if (r_y_o !== e.ry) begin
          $display("%0t: r_y exp %h got %h", $time, e.ry, r_y_o); errors++;
        end
        if (r_z_o !== e.rz) begin
          $display("%0t: r_z exp %h got %h", $time, e.rz, r_z_o); errors++;
        end
        if (zero_quat_error_o !== e.zerr) begin
          $display("%0t: zero_quat_error exp %b got %b", $time, e.zerr,
                   zero_quat_error_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [QW-1:0] ONE = 16384;

  task automatic test_directed();
    send_rot(ONE, 0, 0, 0, 65536, -65536, 12345);
    send_rot(0, 0, 0, 0, VMAX, VMIN, 1);
    send_rot(0, 0, 0, 0, 0, 0, 0);
    send_rot(0, ONE, 0, 0, 65536, 65536, 65536);
    send_rot(0, 0, ONE, 0, VMAX, VMIN, VMAX);
    send_rot(0, 0, 0, ONE, VMIN, VMIN, VMIN);
    send_rot(QMAX, QMAX, QMAX, QMAX, VMAX, VMAX, VMAX);
    send_rot(QMIN, QMIN, QMIN, QMIN, VMIN, VMIN, VMIN);
    send_rot(QMIN, QMAX, QMIN, QMAX, VMAX, VMIN, VMAX);
    send_rot(ONE, ONE, 0, 0, VMAX, VMAX, 0);
    send_rot(1, 1, 1, 1, VMAX, VMIN, VMAX);
    send_rot(1, 0, 0, 1, VMIN, VMAX, 0);
    send_rot(0, 1, 0, 0, -1, 1, -1);
    send_rot(3, -7, 2, 5, 1, -1, 0);
    send_rot(-ONE, 0, 0, 0, -32768, 32768, 1);
    send_rot(ONE, ONE, ONE, ONE, 32768, 32767, -32769);
  endtask

  function automatic logic signed [QW-1:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? QMAX : QMIN;
      1: return QW'($signed(QW'($urandom_range(0, 7))) - 3);
      default: return QW'($urandom);
    endcase
  endfunction

  function automatic logic signed [VW-1:0] rand_vec();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? VMAX : VMIN;
      1: return $signed(VW'($urandom_range(0, 0))) + $signed(VW'($urandom_range(0, 2000))) - 1000;
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0)
        send_rot(0, 0, 0, 0, rand_vec(), rand_vec(), rand_vec());
      else
        send_rot(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                 rand_vec(), rand_vec(), rand_vec());
    end
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (80) @(posedge clk_i);
        hold_off = 0;
      end
      test_random(60);
    join
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (rot_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    rx_busy = 1;
    test_random(350);
    test_backpressure();
    rx_busy = 0;
    test_random(100);
    rx_busy = 1;
    test_random(290);
    drain();
    if (errors == 0 && rot_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
